// ----- sv/stack_push_pop_multiple_unit_macros.svh -----
// Assertion macros for the stack push/pop block.
// Included by the files that carry concurrent checks; needs clk_i and rst_ni in scope.
`ifndef STACK_PUSH_POP_MULTIPLE_UNIT_MACROS_SVH
`define STACK_PUSH_POP_MULTIPLE_UNIT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define SPM_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define SPM_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/spm_pkg.sv -----
// Shared constants and types of the stack push/pop block.
// No dependencies; used by spm_stack_mem and stack_push_pop_multiple_unit.
`default_nettype none

package spm_pkg;

  localparam int unsigned MEM_BYTES = 1024;
  localparam int unsigned NUM_REGS  = 16;
  localparam int unsigned SP_INDEX  = 13;

  localparam int unsigned ADDR_W  = $clog2(MEM_BYTES);
  localparam int unsigned ROWS    = (MEM_BYTES + 3) / 4;
  localparam int unsigned ROW_W   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned RIDX_W  = $clog2(NUM_REGS);

  typedef enum logic [2:0] {
    OP_PUSH  = 3'd0,
    OP_POP   = 3'd1,
    OP_WRREG = 3'd2,
    OP_RDREG = 3'd3,
    OP_RDMEM = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PREP,
    ST_XFER,
    ST_RDREG,
    ST_RDMEM,
    ST_DONE
  } state_e;

  // One word access to the stack memory, any byte alignment.
  typedef struct packed {
    logic              rd;
    logic              wr;
    logic [ADDR_W-1:0] addr;
    logic [31:0]       wdata;
  } mem_req_t;

endpackage

`default_nettype wire

// ----- sv/stack_push_pop_multiple_unit.sv -----
// Top level of the stack push/pop block: sequencer, register file, result register.
// Depends on spm_pkg, spm_stack_mem and stack_push_pop_multiple_unit_macros.svh.
//
// Use:
//   Input channel (in_valid_i / in_stall_o) carries one operation per beat: push, pop,
//   write register, read register or read memory word. Output channel
//   (out_valid_o / out_stall_i) returns one result beat per operation, in order.
//   One operation is worked on at a time; a new beat is taken while a finished
//   result still waits in the output register.
// Transfer:
//   The register file and the byte banks each give one word a cycle; the transfer
//   loop issues the listed registers lowest index first and then completes the last
//   registered read before the block moves on to its final step.
// Reset:
//   rst_ni clears the register file at once (valid bits) and starts a clearing pass
//   over every row of the stack memory, one four-byte row a cycle. in_stall_o stays
//   high until it ends.
// Stall:
//   A held result keeps the block in its final step until out_stall_i falls; input
//   stays stalled meanwhile. Faulting accesses return fault with state untouched.
`default_nettype none

`include "stack_push_pop_multiple_unit_macros.svh"

module stack_push_pop_multiple_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  opcode_i,
  input  logic [15:0] reg_list_i,
  input  logic [3:0]  reg_index_i,
  input  logic [31:0] write_value_i,
  input  logic [9:0]  mem_address_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] read_data_o,
  output logic [31:0] stack_pointer_o,
  output logic        fault_o
);

  localparam int unsigned AW = spm_pkg::ADDR_W;
  localparam int unsigned RW = spm_pkg::ROW_W;
  localparam int unsigned IW = spm_pkg::RIDX_W;
  localparam logic [IW-1:0] SP_IDX = IW'(spm_pkg::SP_INDEX);

  spm_pkg::state_e state_q, state_d;

  // latched operation
  logic [2:0]    op_q;
  logic [15:0]   list_q;
  logic [IW-1:0] idx_q;
  logic [31:0]   wval_q;
  logic [9:0]    maddr_q;

  // sequencer state
  logic [15:0]   mask_q, mask_d;
  logic [AW-1:0] pos_q, pos_d;
  logic          pipe_vld_q, pipe_vld_d;
  logic [IW-1:0] pipe_idx_q, pipe_idx_d;
  logic [AW-1:0] pipe_pos_q, pipe_pos_d;
  logic [31:0]   sp_q, sp_d;
  logic [31:0]   res_data_q, res_data_d;
  logic          res_fault_q, res_fault_d;
  logic [RW-1:0] clr_row_q, clr_row_d;
  logic          out_load;

  // output register
  logic          out_valid_q;
  logic [31:0]   out_data_q;
  logic [31:0]   out_sp_q;
  logic          out_fault_q;

  // register file (entry for the pointer unused; sp_q holds it)
  logic [31:0]       rf_mem_q [spm_pkg::NUM_REGS];
  logic [spm_pkg::NUM_REGS-1:0] rf_vld_q;
  logic [31:0]       rf_rdata_q;
  logic              rf_rvld_q;
  logic [31:0]       rf_rdata;
  logic              rf_we;
  logic [IW-1:0]     rf_waddr;
  logic [31:0]       rf_wdata;
  logic [IW-1:0]     rf_raddr;

  spm_pkg::mem_req_t mem_req;
  logic [31:0]       mem_rdata;

  // list length and range checks
  logic [2:0]  nib_cnt [4];
  logic [4:0]  cnt;
  logic [6:0]  len;
  logic [31:0] push_base;
  logic        push_fault;
  logic [32:0] pop_sum;
  logic        pop_fault;
  logic        rdmem_fault;
  logic        prep_fault;
  logic [IW-1:0] low_idx;

  assign in_stall_o = (state_q != spm_pkg::ST_IDLE);

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      op_q    <= opcode_i;
      list_q  <= reg_list_i;
      idx_q   <= reg_index_i;
      wval_q  <= write_value_i;
      maddr_q <= mem_address_i;
    end
  end

  // popcount as nibble sums, then a sum of four
  always_comb begin
    for (int n = 0; n < 4; n++) begin
      nib_cnt[n] = 3'(list_q[4*n]) + 3'(list_q[4*n+1])
                 + 3'(list_q[4*n+2]) + 3'(list_q[4*n+3]);
    end
    cnt = (5'(nib_cnt[0]) + 5'(nib_cnt[1])) + (5'(nib_cnt[2]) + 5'(nib_cnt[3]));
  end

  assign len         = {cnt, 2'b00};
  assign push_base   = sp_q - 32'(len);
  assign push_fault  = (32'(len) > sp_q) || (sp_q > 32'(spm_pkg::MEM_BYTES));
  assign pop_sum     = {1'b0, sp_q} + 33'(len);
  assign pop_fault   = pop_sum > 33'(spm_pkg::MEM_BYTES);
  assign rdmem_fault = (32'(maddr_q) + 32'd4) > 32'(spm_pkg::MEM_BYTES);

  always_comb begin
    prep_fault = 1'b0;
    case (op_q)
      spm_pkg::OP_PUSH: prep_fault = (len != '0) && push_fault;
      spm_pkg::OP_POP:  prep_fault = (len != '0) && pop_fault;
      spm_pkg::OP_RDMEM: prep_fault = rdmem_fault;
      default: prep_fault = 1'b0;
    endcase
  end

  // lowest register still to move
  always_comb begin
    low_idx = '0;
    for (int i = spm_pkg::NUM_REGS - 1; i >= 0; i--) begin
      if (mask_q[i]) begin
        low_idx = IW'(i);
      end
    end
  end

  assign rf_rdata = rf_rvld_q ? rf_rdata_q : '0;

  always_comb begin
    state_d     = state_q;
    mask_d      = mask_q;
    pos_d       = pos_q;
    pipe_vld_d  = 1'b0;
    pipe_idx_d  = pipe_idx_q;
    pipe_pos_d  = pipe_pos_q;
    sp_d        = sp_q;
    res_data_d  = res_data_q;
    res_fault_d = res_fault_q;
    clr_row_d   = clr_row_q;
    out_load    = 1'b0;
    rf_we       = 1'b0;
    rf_waddr    = pipe_idx_q;
    rf_wdata    = mem_rdata;
    rf_raddr    = idx_q;
    mem_req     = '0;
    mem_req.addr = pos_q;

    case (state_q)
      spm_pkg::ST_CLEAR: begin
        mem_req.wr   = 1'b1;
        mem_req.addr = AW'({clr_row_q, 2'b00});
        if (clr_row_q == RW'(spm_pkg::ROWS - 1)) begin
          state_d = spm_pkg::ST_IDLE;
        end else begin
          clr_row_d = clr_row_q + 1'b1;
        end
      end

      spm_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = spm_pkg::ST_PREP;
        end
      end

      spm_pkg::ST_PREP: begin
        res_data_d  = '0;
        res_fault_d = prep_fault;
        state_d     = spm_pkg::ST_DONE;
        case (op_q)
          spm_pkg::OP_PUSH: begin
            if (len != '0 && !push_fault) begin
              sp_d    = push_base;
              pos_d   = push_base[AW-1:0];
              mask_d  = list_q;
              state_d = spm_pkg::ST_XFER;
            end
          end
          spm_pkg::OP_POP: begin
            if (len != '0 && !pop_fault) begin
              sp_d    = pop_sum[31:0];
              pos_d   = sp_q[AW-1:0];
              mask_d  = list_q;
              state_d = spm_pkg::ST_XFER;
            end
          end
          spm_pkg::OP_WRREG: begin
            if (idx_q == SP_IDX) begin
              sp_d = wval_q;
            end else begin
              rf_we    = 1'b1;
              rf_waddr = idx_q;
              rf_wdata = wval_q;
            end
          end
          spm_pkg::OP_RDREG: begin
            if (idx_q == SP_IDX) begin
              res_data_d = sp_q;
            end else begin
              state_d = spm_pkg::ST_RDREG;
            end
          end
          spm_pkg::OP_RDMEM: begin
            if (!rdmem_fault) begin
              mem_req.rd   = 1'b1;
              mem_req.addr = AW'(maddr_q);
              state_d      = spm_pkg::ST_RDMEM;
            end
          end
          default: ;
        endcase
      end

      spm_pkg::ST_XFER: begin
        // issue side: one listed register a cycle
        if (mask_q != '0) begin
          pipe_vld_d = 1'b1;
          pipe_idx_d = low_idx;
          pipe_pos_d = pos_q;
          pos_d      = pos_q + AW'(4);
          mask_d     = mask_q & (mask_q - 16'd1);
          rf_raddr   = low_idx;
          if (op_q == spm_pkg::OP_POP) begin
            mem_req.rd   = 1'b1;
            mem_req.addr = pos_q;
          end
        end
        // completion side: data read last cycle
        if (pipe_vld_q) begin
          if (op_q == spm_pkg::OP_PUSH) begin
            mem_req.wr    = 1'b1;
            mem_req.addr  = pipe_pos_q;
            mem_req.wdata = (pipe_idx_q == SP_IDX) ? sp_q : rf_rdata;
          end else if (pipe_idx_q == SP_IDX) begin
            sp_d = mem_rdata;
          end else begin
            rf_we = 1'b1;
          end
        end
        if (mask_q == '0 && !pipe_vld_q) begin
          state_d = spm_pkg::ST_DONE;
        end
      end

      spm_pkg::ST_RDREG: begin
        res_data_d = rf_rdata;
        state_d    = spm_pkg::ST_DONE;
      end

      spm_pkg::ST_RDMEM: begin
        res_data_d = mem_rdata;
        state_d    = spm_pkg::ST_DONE;
      end

      spm_pkg::ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = spm_pkg::ST_IDLE;
        end
      end

      default: state_d = spm_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= spm_pkg::ST_CLEAR;
      clr_row_q   <= '0;
      pipe_vld_q  <= 1'b0;
      sp_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      clr_row_q  <= clr_row_d;
      pipe_vld_q <= pipe_vld_d;
      sp_q       <= sp_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mask_q      <= mask_d;
    pos_q       <= pos_d;
    pipe_idx_q  <= pipe_idx_d;
    pipe_pos_q  <= pipe_pos_d;
    res_data_q  <= res_data_d;
    res_fault_q <= res_fault_d;
    if (out_load) begin
      out_data_q  <= res_data_d;
      out_sp_q    <= sp_q;
      out_fault_q <= res_fault_d;
    end
  end

  // register file: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (rf_we) begin
      rf_mem_q[rf_waddr] <= rf_wdata;
    end
    rf_rdata_q <= rf_mem_q[rf_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rf_vld_q  <= '0;
      rf_rvld_q <= 1'b0;
    end else begin
      if (rf_we) begin
        rf_vld_q[rf_waddr] <= 1'b1;
      end
      rf_rvld_q <= rf_vld_q[rf_raddr];
    end
  end

  spm_stack_mem u_stack_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  assign out_valid_o     = out_valid_q;
  assign read_data_o     = out_data_q;
  assign stack_pointer_o = out_sp_q;
  assign fault_o         = out_fault_q;

  `SPM_ASSERT_IMP(a_pop_no_mem_wr, state_q == spm_pkg::ST_XFER && op_q == spm_pkg::OP_POP, !mem_req.wr, "stack memory written during pop")
  `SPM_ASSERT_IMP(a_push_no_rf_wr, state_q == spm_pkg::ST_XFER && op_q == spm_pkg::OP_PUSH, !rf_we, "register file written during push")
  `SPM_ASSERT_NXT(a_fault_keeps_sp, state_q == spm_pkg::ST_PREP && prep_fault, $stable(sp_q), "pointer moved on a faulting access")
  `SPM_ASSERT_IMP(a_idle_drained, state_q == spm_pkg::ST_IDLE, !pipe_vld_q, "transfer pipeline busy while idle")

endmodule

`default_nettype wire

// ----- sv/spm_stack_mem.sv -----
// Byte-addressed stack memory as four byte banks, one word access per cycle.
// Depends on spm_pkg; read data is registered and appears in the cycle after the request.
`default_nettype none

module spm_stack_mem (
  input  logic              clk_i,
  input  spm_pkg::mem_req_t req_i,
  output logic [31:0]       rdata_o
);

  logic [1:0] off;
  logic [1:0] off_q;
  wire  [7:0] rd_bytes [4];

  assign off = req_i.addr[1:0];

  always_ff @(posedge clk_i) begin
    if (req_i.rd) begin
      off_q <= off;
    end
  end

  // bank b holds bytes whose address mod 4 is b
  for (genvar b = 0; b < 4; b++) begin : g_bank
    localparam logic [1:0] BANK = 2'(b);

    logic [7:0]                 bank_q [spm_pkg::ROWS];
    logic [7:0]                 rd_q;
    logic [spm_pkg::ADDR_W-2:0] row_sum;
    logic [spm_pkg::ROW_W-1:0]  row;
    logic [1:0]                 lane;
    logic [7:0]                 wbyte;

    // banks below the start offset take the next row
    assign row_sum = {1'b0, req_i.addr[spm_pkg::ADDR_W-1:2]}
                   + (spm_pkg::ADDR_W-1)'(BANK < off);
    assign row     = row_sum[spm_pkg::ROW_W-1:0];
    assign lane    = BANK - off;
    assign wbyte   = req_i.wdata[8*lane +: 8];

    always_ff @(posedge clk_i) begin
      if (req_i.wr) begin
        bank_q[row] <= wbyte;
      end
      if (req_i.rd) begin
        rd_q <= bank_q[row];
      end
    end

    assign rd_bytes[b] = rd_q;
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      rdata_o[8*k +: 8] = rd_bytes[2'(off_q + 2'(k))];
    end
  end

endmodule

`default_nettype wire
